[hw/rtl/b2b_pkg.sv]
// Package: BLAKE2b constants, sigma table and shared controller/datapath types
`timescale 1ns / 1ps
package b2b_pkg;

  localparam int WordW = 64;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 7;
  localparam int Rounds = 12;

  localparam logic [CfgIdxW-1:0] CFG_KEY_LENGTH = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIGEST_LENGTH = 1'd1;

  localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;

  function automatic logic [63:0] iv_word(input logic [2:0] i);
    logic [63:0] v;
    case (i)
      3'd0: v = 64'h6A09E667F3BCC908;
      3'd1: v = 64'hBB67AE8584CAA73B;
      3'd2: v = 64'h3C6EF372FE94F82B;
      3'd3: v = 64'hA54FF53A5F1D36F1;
      3'd4: v = 64'h510E527FADE682D1;
      3'd5: v = 64'h9B05688C2B3E6C1F;
      3'd6: v = 64'h1F83D9ABFB41BD6B;
      default: v = 64'h5BE0CD19137E2179;
    endcase
    return v;
  endfunction

  // sigma row as 16 nibbles, entry 0 in the low nibble
  function automatic logic [63:0] sigma_row(input logic [3:0] r);
    logic [63:0] v;
    case (r)
      4'd0: v = 64'hFEDCBA9876543210;
      4'd1: v = 64'h357B20C16DF984AE;
      4'd2: v = 64'h491763EADF250C8B;
      4'd3: v = 64'h8F04A562EBCD1397;
      4'd4: v = 64'hD386CB1EFA427509;
      4'd5: v = 64'h91EF57D438B0A6C2;
      4'd6: v = 64'hB8293670A4DEF15C;
      4'd7: v = 64'hA2684F05931CE7BD;
      4'd8: v = 64'h5A417D2C803B9EF6;
      4'd9: v = 64'h0DC3E9BF5167482A;
      default: v = 64'hFEDCBA9876543210;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic start_msg;   // reload chain and restart the byte counter
    logic store_word;  // write word into buffer
    logic clear_buf;   // zero the buffer and its fill count
    logic init_work;   // load working vector
    logic final_blk;   // final flag for init_work
    logic half_step;   // one half-round
    logic half_sel;    // 0 column, 1 diagonal
    logic [3:0] round;
    logic fold;        // xor working vector into chain
  } b2b_cmd_t;

  typedef struct packed {
    logic [4:0] fill;
  } b2b_status_t;

endpackage

[hw/rtl/b2b_datapath.sv]
// Datapath: chain value, block buffer, byte counter and the half-round unit
`timescale 1ns / 1ps
module b2b_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  b2b_pkg::b2b_cmd_t         cmd,
  output b2b_pkg::b2b_status_t      status,
  input  logic [63:0]               word_in,
  input  logic [3:0]                nbytes_in,
  input  logic [6:0]                key_length,
  input  logic [6:0]                digest_length,
  input  logic [2:0]                rd_idx,
  output logic [63:0]               rd_word
);
  import b2b_pkg::*;

  logic [63:0] h_r [8];
  logic [63:0] m_r [16];
  logic [63:0] v_r [16];
  logic [63:0] cnt_r;
  logic [4:0]  fill_r;

  logic [3:0]  nb;
  logic [63:0] masked;
  logic [63:0] sig;
  logic [63:0] v_nxt [16];

  assign status.fill = fill_r;
  assign rd_word = h_r[rd_idx];

  always_comb begin
    nb = (nbytes_in > 4'd8) ? 4'd8 : nbytes_in;
    masked = '0;
    for (int b = 0; b < 8; b++)
      if (4'(b) < nb) masked[b*8 +: 8] = word_in[b*8 +: 8];
  end

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  always_comb begin
    logic [63:0] a, b, c, d, x, y;
    logic [3:0] ia, ib, ic, id;
    logic [3:0] rr;
    rr = (cmd.round >= 4'd10) ? cmd.round - 4'd10 : cmd.round;
    sig = sigma_row(rr);
    for (int k = 0; k < 16; k++) v_nxt[k] = v_r[k];
    for (int g = 0; g < 4; g++) begin
      ia = 4'(g);
      ib = cmd.half_sel ? 4'(4 + ((g + 1) % 4)) : 4'(4 + g);
      ic = cmd.half_sel ? 4'(8 + ((g + 2) % 4)) : 4'(8 + g);
      id = cmd.half_sel ? 4'(12 + ((g + 3) % 4)) : 4'(12 + g);
      x = m_r[sig[(cmd.half_sel ? 32 : 0) + g*8 +: 4]];
      y = m_r[sig[(cmd.half_sel ? 32 : 0) + g*8 + 4 +: 4]];
      a = v_r[ia]; b = v_r[ib]; c = v_r[ic]; d = v_r[id];
      a = a + b + x;
      d = rotr(d ^ a, 32);
      c = c + d;
      b = rotr(b ^ c, 24);
      a = a + b + y;
      d = rotr(d ^ a, 16);
      c = c + d;
      b = rotr(b ^ c, 63);
      v_nxt[ia] = a; v_nxt[ib] = b; v_nxt[ic] = c; v_nxt[id] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
      for (int i = 0; i < 16; i++) m_r[i] <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= iv_word(3'(i));
      h_r[0] <= iv_word(3'd0) ^ PARAM_BASE ^ 64'(64 << 0) ^ 64'd0;
    end else begin
      if (cmd.start_msg) begin
        for (int i = 0; i < 8; i++) h_r[i] <= iv_word(3'(i));
        h_r[0] <= iv_word(3'd0) ^ PARAM_BASE ^ {49'd0, key_length, 8'd0}
                  ^ {57'd0, digest_length};
      end
      if (cmd.clear_buf) begin
        for (int i = 0; i < 16; i++) m_r[i] <= '0;
        fill_r <= '0;
        if (cmd.start_msg) cnt_r <= '0;
      end else if (cmd.store_word) begin
        m_r[fill_r[3:0]] <= masked;
        fill_r <= fill_r + 5'd1;
        cnt_r  <= (cmd.start_msg ? 64'd0 : cnt_r) + {60'd0, nb};
      end
      if (cmd.init_work) begin
        for (int i = 0; i < 8; i++) begin
          v_r[i]   <= h_r[i];
          v_r[i+8] <= iv_word(3'(i));
        end
        v_r[12] <= iv_word(3'd4) ^ cnt_r;
        v_r[14] <= cmd.final_blk ? ~iv_word(3'd6) : iv_word(3'd6);
      end else if (cmd.half_step) begin
        for (int i = 0; i < 16; i++) v_r[i] <= v_nxt[i];
      end
      if (cmd.fold)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] ^ v_r[i] ^ v_r[i+8];
    end
  end
endmodule

[hw/rtl/b2b_ctrl.sv]
// Controller: sequences word intake, compressions and digest output
`timescale 1ns / 1ps
module b2b_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_last,
  input  logic [3:0]            in_nbytes,
  input  b2b_pkg::b2b_status_t  status,
  output b2b_pkg::b2b_cmd_t     cmd,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_idx
);
  import b2b_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_ROUND, S_FOLD, S_STORE, S_OUT} state_t;

  state_t      state_r, state_nxt;
  logic        busy_r, busy_nxt;
  logic        fin_r, fin_nxt;      // this compress is the final one
  logic        pend_r, pend_nxt;    // held word is the last one of the message
  logic [4:0]  step_r, step_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        acc;
  logic        full;

  assign in_stall  = (state_r != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign full      = status.fill[4];
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = idx_r;

  always_comb begin
    state_nxt = state_r; busy_nxt = busy_r; fin_nxt = fin_r; pend_nxt = pend_r;
    step_nxt = step_r; idx_nxt = idx_r;
    cmd = '0;
    cmd.round = step_r[4:1];
    cmd.half_sel = step_r[0];
    cmd.final_blk = fin_r;
    unique case (state_r)
      S_IDLE: if (acc) begin
        busy_nxt = 1'b1;
        if (!busy_r) begin
          cmd.start_msg = 1'b1;
          cmd.clear_buf = 1'b1;
          state_nxt = S_STORE;   // store after clear
          fin_nxt = 1'b0;
          pend_nxt = in_last;
        end else if (full) begin
          if (in_last && in_nbytes == 4'd0) begin
            fin_nxt = 1'b1; pend_nxt = 1'b0;
          end else begin
            fin_nxt = 1'b0; pend_nxt = in_last;
          end
          state_nxt = S_INIT;
        end else begin
          cmd.store_word = 1'b1;
          if (in_last) begin
            fin_nxt = 1'b1; pend_nxt = 1'b0; state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init_work = 1'b1;
        step_nxt = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.half_step = 1'b1;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(2*Rounds - 1)) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (fin_r) begin
          idx_nxt = '0; state_nxt = S_OUT;
        end else begin
          cmd.clear_buf = 1'b1;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        // the held word; in_* are stable only while stalled, so it is
        // captured by the top level
        cmd.store_word = 1'b1;
        pend_nxt = 1'b0;
        fin_nxt = pend_r;
        state_nxt = pend_r ? S_INIT : S_IDLE;
      end
      S_OUT: if (!out_stall) begin
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          cmd.clear_buf = 1'b1;
          busy_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; busy_r <= 1'b0; fin_r <= 1'b0; pend_r <= 1'b0;
      step_r <= '0; idx_r <= '0;
    end else begin
      state_r <= state_nxt; busy_r <= busy_nxt; fin_r <= fin_nxt; pend_r <= pend_nxt;
      step_r <= step_nxt; idx_r <= idx_nxt;
    end
  end
endmodule

[hw/rtl/blake2b_hash_core.sv]
// Top level: BLAKE2b-512 hash core with word input and digest word output
//
//  channel | ports                                        | direction
//  in      | in_valid in_stall in_message_word ...        | message words in
//  out     | out_valid out_stall out_digest_word ...      | digest words out
//  cfg     | cfg_we cfg_index cfg_data                    | register writes
//
// A word into a non-full block of a message under way is stored when accepted;
// the first word of a message is stored after a clear. A word that follows a
// full block first runs one compression: accept, init, the half-rounds of
// every round, fold, then store. The last word adds a compression (init,
// half-rounds, fold) and 8 output transfers, each held while out_stall is high.
// The half-round unit is shared by all rounds. Reset is synchronous; the block
// buffer is cleared by reset and per message.
`timescale 1ns / 1ps
module blake2b_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [b2b_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [b2b_pkg::CfgDataW-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_message_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_digest_last
);
  import b2b_pkg::*;

  logic [6:0]  key_len_r, dig_len_r;
  logic [63:0] word_r;
  logic [3:0]  nb_r;
  logic        acc;
  b2b_cmd_t    cmd;
  b2b_status_t status;

  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= 7'd0;
      dig_len_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LENGTH:    key_len_r <= cfg_data;
        CFG_DIGEST_LENGTH: dig_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // word held for deferred store after a clear or a compression
  always_ff @(posedge clk) begin
    if (acc) begin
      word_r <= in_message_word;
      nb_r   <= in_valid_bytes;
    end
  end

  b2b_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_last(in_last_word), .in_nbytes(in_valid_bytes),
    .status, .cmd, .out_valid, .out_stall, .out_idx(out_digest_index)
  );

  b2b_datapath u_dp (
    .clk, .rst_n, .cmd, .status,
    .word_in(in_stall ? word_r : in_message_word),
    .nbytes_in(in_stall ? nb_r : in_valid_bytes),
    .key_length(key_len_r), .digest_length(dig_len_r),
    .rd_idx(out_digest_index), .rd_word(out_digest_word)
  );

  assign out_digest_last = (out_digest_index == 3'd7);
endmodule

[sim/tb.sv]
// Testbench: BLAKE2b hash core checked word by word against a behavioural digest predictor
`timescale 1ns / 1ps
module tb;
  import b2b_pkg::*;

  class digest_board;
    logic [63:0] exp_word[$];
    logic [2:0]  exp_idx[$];
    logic        exp_last[$];
    int errors;
    int matched;
    logic [6:0] key_len;
    logic [6:0] dig_len;
    logic [63:0] h[8];
    logic [63:0] buf_w[16];
    logic [63:0] byte_cnt;
    int fill;
    bit busy;

    function void init();
      errors = 0;
      matched = 0;
      key_len = 0;
      dig_len = 64;
      busy = 0;
      fill = 0;
      byte_cnt = 0;
      foreach (buf_w[i]) buf_w[i] = '0;
    endfunction

    function logic [63:0] ivw(int i);
      case (i)
        0: return 64'h6A09E667F3BCC908;
        1: return 64'hBB67AE8584CAA73B;
        2: return 64'h3C6EF372FE94F82B;
        3: return 64'hA54FF53A5F1D36F1;
        4: return 64'h510E527FADE682D1;
        5: return 64'h9B05688C2B3E6C1F;
        6: return 64'h1F83D9ABFB41BD6B;
        default: return 64'h5BE0CD19137E2179;
      endcase
    endfunction

    function int perm(int r, int i);
      int p[10][16] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
        '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
        '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
        '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
        '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
        '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
        '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
        '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
        '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};
      return p[r][i];
    endfunction

    function logic [63:0] ror(logic [63:0] v, int n);
      return (v >> n) | (v << (64 - n));
    endfunction

    function void mix(ref logic [63:0] v[16], input int a, int b, int c, int d,
                      input logic [63:0] x, logic [63:0] y);
      v[a] = v[a] + v[b] + x;
      v[d] = ror(v[d] ^ v[a], 32);
      v[c] = v[c] + v[d];
      v[b] = ror(v[b] ^ v[c], 24);
      v[a] = v[a] + v[b] + y;
      v[d] = ror(v[d] ^ v[a], 16);
      v[c] = v[c] + v[d];
      v[b] = ror(v[b] ^ v[c], 63);
    endfunction

    function void compress(bit fin);
      logic [63:0] v[16];
      int s;
      for (int i = 0; i < 8; i++) begin
        v[i] = h[i];
        v[i + 8] = ivw(i);
      end
      v[12] ^= byte_cnt;
      if (fin) v[14] = ~v[14];
      for (int r = 0; r < 12; r++) begin
        s = r % 10;
        mix(v, 0, 4, 8, 12, buf_w[perm(s, 0)], buf_w[perm(s, 1)]);
        mix(v, 1, 5, 9, 13, buf_w[perm(s, 2)], buf_w[perm(s, 3)]);
        mix(v, 2, 6, 10, 14, buf_w[perm(s, 4)], buf_w[perm(s, 5)]);
        mix(v, 3, 7, 11, 15, buf_w[perm(s, 6)], buf_w[perm(s, 7)]);
        mix(v, 0, 5, 10, 15, buf_w[perm(s, 8)], buf_w[perm(s, 9)]);
        mix(v, 1, 6, 11, 12, buf_w[perm(s, 10)], buf_w[perm(s, 11)]);
        mix(v, 2, 7, 8, 13, buf_w[perm(s, 12)], buf_w[perm(s, 13)]);
        mix(v, 3, 4, 9, 14, buf_w[perm(s, 14)], buf_w[perm(s, 15)]);
      end
      for (int i = 0; i < 8; i++) h[i] ^= v[i] ^ v[i + 8];
    endfunction

    function void wipe();
      foreach (buf_w[i]) buf_w[i] = '0;
      fill = 0;
    endfunction

    function void note_word(logic [63:0] w, logic [3:0] nb_in, logic last);
      int nb;
      nb = (nb_in > 8) ? 8 : nb_in;
      if (nb < 8) w &= (64'd1 << (8 * nb)) - 64'd1;
      if (!busy) begin
        for (int i = 0; i < 8; i++) h[i] = ivw(i);
        h[0] ^= 64'h0101_0000 ^ (64'(key_len) << 8) ^ 64'(dig_len);
        wipe();
        byte_cnt = 0;
        busy = 1;
      end
      if (!(last && nb == 0 && fill >= 16)) begin
        if (fill >= 16) begin
          compress(0);
          wipe();
        end
        buf_w[fill] = w;
        fill++;
        byte_cnt += 64'(nb);
      end
      if (!last) return;
      compress(1);
      for (int i = 0; i < 8; i++) begin
        exp_word.push_back(h[i]);
        exp_idx.push_back(3'(i));
        exp_last.push_back(i == 7);
      end
      wipe();
      byte_cnt = 0;
      busy = 0;
    endfunction

    function void check_digest(logic [63:0] w, logic [2:0] idx, logic lst);
      if (exp_word.size() == 0) begin
        $error("digest word with nothing expected: %h", w);
        errors++;
        return;
      end
      if (w !== exp_word[0]) begin
        $error("digest_word expected %h actual %h", exp_word[0], w);
        errors++;
      end
      if (idx !== exp_idx[0]) begin
        $error("digest_index expected %0d actual %0d", exp_idx[0], idx);
        errors++;
      end
      if (lst !== exp_last[0]) begin
        $error("digest_last expected %0d actual %0d", exp_last[0], lst);
        errors++;
      end
      void'(exp_word.pop_front());
      void'(exp_idx.pop_front());
      void'(exp_last.pop_front());
      matched++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [63:0] in_message_word = '0;
  logic [3:0] in_valid_bytes = '0;
  logic in_last_word = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [63:0] out_digest_word;
  logic [2:0] out_digest_index;
  logic out_digest_last;

  digest_board board;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cycles = 0;
  longint cycles = 0;
  int words_sent = 0;
  int msgs_sent = 0;

  always #4 clk = ~clk;

  blake2b_hash_core i_dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_digest(out_digest_word, out_digest_index, out_digest_last);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [6:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_KEY_LENGTH) board.key_len = val;
    else board.dig_len = val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // valid stays high after a transfer so the next word can follow at once
  task automatic send_word(logic [63:0] w, logic [3:0] nb, logic last);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_message_word <= w;
    in_valid_bytes <= nb;
    in_last_word <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(w, nb, last);
    words_sent++;
    if (last) msgs_sent++;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // n full words then a last word carrying tail bytes
  task automatic send_message(int n, logic [3:0] tail);
    for (int i = 0; i < n; i++) send_word(rnd64(), 4'd8, 0);
    send_word(rnd64(), tail, 1);
  endtask

  task automatic send_keyed(int n, logic [3:0] tail);
    for (int i = 0; i < 16; i++)
      send_word(i < (board.key_len + 7) / 8 ? rnd64() : 64'd0, 4'd8, 0);
    send_message(n, tail);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.exp_word.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    board = new();
    board.init();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, empty message, block boundaries, odd byte counts
    send_word(64'd0, 4'd0, 1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 0); // short word mid-message
    send_word(64'h0123_4567_89AB_CDEF, 4'd5, 1);
    send_message(15, 4'd8);
    send_message(16, 4'd0);                      // empty last on full block
    send_message(16, 4'd1);
    send_message(31, 4'd7);
    drain();
    write_reg(CFG_KEY_LENGTH, 7'd64);
    write_reg(CFG_DIGEST_LENGTH, 7'd1);
    send_keyed(0, 4'd0);
    send_keyed(2, 4'd4);
    drain();
    write_reg(CFG_KEY_LENGTH, 7'd127);
    write_reg(CFG_DIGEST_LENGTH, 7'd127);
    send_message(1, 4'd2);
    // a write during a message must wait for the next one
    send_word(rnd64(), 4'd8, 0);
    drain();
    write_reg(CFG_KEY_LENGTH, 7'd0);
    send_word(rnd64(), 4'd8, 1);
    drain();
    write_reg(CFG_DIGEST_LENGTH, 7'd64);

    // long receiver hold-off while the sender keeps offering transfers
    hold_cycles = 600;
    send_message(3, 4'd8);
    send_message(20, 4'd6);
    send_message(2, 4'd8);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_gap = (ph == 0) ? 8 : (ph == 1) ? 51 : 0;
      recv_gap = (ph == 0) ? 51 : (ph == 1) ? 8 : 0;
      write_reg(CFG_KEY_LENGTH, (ph == 1) ? 7'd32 : 7'd0);
      write_reg(CFG_DIGEST_LENGTH, 7'($urandom_range(1, 64)));
      for (int m = 0; m < 3; m++) begin
        if ($urandom_range(9) == 0) send_word(rnd64(), 4'($urandom()), 1);
        else if (board.key_len != 0) send_keyed($urandom_range(0, 5), 4'($urandom_range(0, 8)));
        else send_message(m == 2 ? $urandom_range(14, 20) : $urandom_range(0, 9),
                          4'($urandom_range(0, 15)));
      end
      drain();
    end

    $display("Sent %0d words in %0d messages; %0d digest words checked.",
             words_sent, msgs_sent, board.matched);
    $display("Covered keyed and plain messages, block boundaries and both stall patterns.");
    if (board.errors == 0 && board.exp_word.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
